/* src/uule_pkg.sv */
package uule_pkg;

	// bytes per full line and index width into one line bank
	localparam int LINE_BYTES = 45;
	localparam int IDX_W      = 6;
	localparam int ADDR_W     = IDX_W + 1;
	localparam int MEM_DEPTH  = 1 << ADDR_W;

	// request codes
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// fixed characters
	localparam logic [6:0] CH_NL = 7'd10;
	localparam logic [6:0] CH_SP = 7'd32;

	localparam logic [IDX_W-1:0] FULL_N = IDX_W'(LINE_BYTES);

	// one line job handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] n;
		logic             term;
		logic             bank;
	} job_t;

	// line store write from the front
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// bank release from the back
	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

	function automatic logic [6:0] enc6(input logic [5:0] v);
		enc6 = {1'b0, v} + 7'd32;
	endfunction

endpackage

/* src/uule_front.sv */
module uule_front import uule_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job,
	output wr_t        wr,
	input  rel_t       rel
);

	logic [IDX_W-1:0] count_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [1:0]       busy_d;
	logic             accept;
	logic             line_done;
	logic             hand_off;

	assign in_ready = !q_full && !busy_q[bank_q];
	assign accept   = in_valid && in_ready;

	// store write for data bytes
	assign wr.en   = accept && (req_type == REQ_DATA);
	assign wr.addr = {bank_q, count_q};
	assign wr.data = data_byte;

	assign line_done = (req_type == REQ_DATA) ? (count_q == FULL_N - IDX_W'(1)) : 1'b1;

	assign q_push      = accept && line_done;
	assign q_job.n     = (req_type == REQ_DATA) ? FULL_N : count_q;
	assign q_job.term  = (req_type == REQ_END);
	assign q_job.bank  = bank_q;

	// a non-empty line hands its bank to the back
	assign hand_off = q_push && (q_job.n != '0);

	always_comb begin
		busy_d = busy_q;
		if (rel.en) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (hand_off) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= busy_d;
			if (hand_off) begin
				bank_q <= !bank_q;
			end
			if (accept) begin
				if (line_done) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

/* src/uule_queue.sv */
module uule_queue import uule_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/uule_back.sv */
module uule_back import uule_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wr_t        wr,
	input  logic       q_empty,
	input  job_t       q_head,
	output logic       q_pop,
	output rel_t       rel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       last_of_run
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LEN, ST_RD, ST_E0, ST_E1, ST_E2, ST_E3, ST_NL, ST_TSP, ST_TNL
	} state_t;

	state_t           state_q;
	logic [7:0]       mem_q [MEM_DEPTH];
	logic [7:0]       rdata_s1;
	logic             rd_vld_s1;
	logic [1:0]       rd_slot_s1;
	logic             rd_keep_s1;
	logic [IDX_W-1:0] n_q;
	logic             term_q;
	logic             bank_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       rd_cnt_q;
	logic [7:0]       grp_q [3];
	logic             out_vld_q;
	logic [6:0]       out_char_q;
	logic             out_last_q;

	logic             can_emit;
	logic             emit;
	logic             rd_issue;
	logic [IDX_W:0]   rd_pos;
	logic             rd_keep;
	logic [IDX_W:0]   next_idx;
	logic [ADDR_W-1:0] raddr;

	assign can_emit = !out_vld_q || out_ready;
	assign rd_issue = (state_q == ST_RD) && (rd_cnt_q != 2'd3);
	assign rd_pos   = {1'b0, idx_q} + {{(IDX_W-1){1'b0}}, rd_cnt_q};
	// bytes past the line end pad as zero
	assign rd_keep  = rd_pos < {1'b0, n_q};
	assign raddr    = {bank_q, rd_pos[IDX_W-1:0]};
	assign next_idx = {1'b0, idx_q} + (IDX_W+1)'(3);

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign rel.en   = (state_q == ST_NL) && can_emit;
	assign rel.bank = bank_q;

	assign out_valid   = out_vld_q;
	assign out_char    = out_char_q;
	assign last_of_run = out_last_q;

	// a character goes into the output register this cycle
	always_comb begin
		case (state_q)
			ST_LEN, ST_E0, ST_E1, ST_E2, ST_E3, ST_NL, ST_TSP, ST_TNL: emit = can_emit;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_vld_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_cnt_q   <= '0;
			out_char_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1  <= rd_issue;
			rd_slot_s1 <= rd_cnt_q;
			rd_keep_s1 <= rd_keep;
			if (rd_vld_s1) begin
				grp_q[rd_slot_s1] <= rd_keep_s1 ? rdata_s1 : 8'd0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						n_q    <= q_head.n;
						term_q <= q_head.term;
						bank_q <= q_head.bank;
						state_q <= (q_head.n != '0) ? ST_LEN : ST_TSP;
					end
				end
				ST_LEN: begin
					if (can_emit) begin
						out_char_q <= enc6(n_q);
						out_last_q <= 1'b0;
						idx_q      <= '0;
						rd_cnt_q   <= '0;
						state_q    <= ST_RD;
					end
				end
				ST_RD: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + 2'd1;
					end
					if (rd_vld_s1 && rd_slot_s1 == 2'd2) begin
						state_q <= ST_E0;
					end
				end
				ST_E0: begin
					if (can_emit) begin
						out_char_q <= enc6(grp_q[0][7:2]);
						out_last_q <= 1'b0;
						state_q    <= ST_E1;
					end
				end
				ST_E1: begin
					if (can_emit) begin
						out_char_q <= enc6({grp_q[0][1:0], grp_q[1][7:4]});
						out_last_q <= 1'b0;
						state_q    <= ST_E2;
					end
				end
				ST_E2: begin
					if (can_emit) begin
						out_char_q <= enc6({grp_q[1][3:0], grp_q[2][7:6]});
						out_last_q <= 1'b0;
						state_q    <= ST_E3;
					end
				end
				ST_E3: begin
					if (can_emit) begin
						out_char_q <= enc6(grp_q[2][5:0]);
						out_last_q <= 1'b0;
						idx_q      <= next_idx[IDX_W-1:0];
						rd_cnt_q   <= '0;
						state_q    <= (next_idx < {1'b0, n_q}) ? ST_RD : ST_NL;
					end
				end
				ST_NL: begin
					if (can_emit) begin
						out_char_q <= CH_NL;
						out_last_q <= !term_q;
						state_q    <= term_q ? ST_TSP : ST_IDLE;
					end
				end
				ST_TSP: begin
					if (can_emit) begin
						out_char_q <= CH_SP;
						out_last_q <= 1'b0;
						state_q    <= ST_TNL;
					end
				end
				ST_TNL: begin
					if (can_emit) begin
						out_char_q <= CH_NL;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/uuencode_line_encoder.sv */
// streaming uuencode line encoder
// input channel: in_valid / in_ready carries req_type and data_byte; a data
//   transaction stores one byte, an end transaction flushes the partial line
//   and appends the terminating line (space, newline)
// output channel: out_valid / out_ready carries one character per transaction;
//   last_of_run marks the final character caused by one input transaction
// a data byte that does not complete a line causes no output
// throughput: input takes one byte per cycle while the current line bank is
//   free and the job queue is not full; output gives the length character,
//   then per group of three bytes three store reads and four characters, then
//   the newline, after picking up a line job; store reads and character output
//   take turns in the back
// two line banks let the front fill one line while the back emits the other
// reset: line empty, queue empty, output idle; store contents stay undefined
// receiver stall: the output register holds, the back stops, and the front
//   keeps taking bytes until the job queue fills or both banks are in use
module uuencode_line_encoder import uule_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       last_of_run
);

	// front to queue
	logic q_full;
	logic q_push;
	job_t q_job;

	// queue to back
	logic q_empty;
	logic q_pop;
	job_t q_head;

	// store write path and bank release
	wr_t  wr;
	rel_t rel;

	// accepts transactions, fills the line banks, posts line jobs
	uule_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job),
		.wr        (wr),
		.rel       (rel)
	);

	// two-entry job queue between front and back
	uule_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// reads the line store and emits characters
	uule_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.rel         (rel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

/* bench/uuencode_line_encoder_tb.sv */
`timescale 1ns / 100ps

module uuencode_line_encoder_tb;
	import uule_pkg::*;

	// run limits; all but RANDOM_ITEMS in clock cycles
	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES  = 600;
	localparam int RANDOM_ITEMS = 50;

	// receiver stall patterns
	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	// one encoded character as the block should emit it
	typedef struct {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] out_char;
	logic       last_of_run;

	// predictor state: bytes of the line being collected
	logic [7:0] held_bytes [LINE_BYTES];
	int         held_len;

	// characters still owed by the block, oldest first
	enc_char_t  pending_chars [$];

	int  errors;
	int  cycle_cnt;
	int  burst_left;
	bit  gaps_on;
	int  hold_reqs;

	uuencode_line_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// six bits to a printable character: value plus space
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		return 7'(v) + 7'd32;
	endfunction

	function automatic void push_char(input logic [6:0] c);
		enc_char_t e;
		e.ch   = c;
		e.last = 1'b0;
		pending_chars.push_back(e);
	endfunction

	// length character, four characters per group of three, newline;
	// a short last group is padded with zero bytes, never stale store data
	function automatic void emit_line(input int n);
		logic [7:0] b0, b1, b2;
		push_char(sextet_char(6'(n)));
		for (int i = 0; i < n; i += 3) begin
			b0 = held_bytes[i];
			b1 = (i + 1 < n) ? held_bytes[i + 1] : 8'h00;
			b2 = (i + 2 < n) ? held_bytes[i + 2] : 8'h00;
			push_char(sextet_char(b0[7:2]));
			push_char(sextet_char({b0[1:0], b1[7:4]}));
			push_char(sextet_char({b1[3:0], b2[7:6]}));
			push_char(sextet_char(b2[5:0]));
		end
		push_char(CH_NL);
	endfunction

	// expected characters for one accepted input transaction
	function automatic void encode_item(input logic rt, input logic [7:0] b);
		int first;
		first = pending_chars.size();
		if (rt == REQ_DATA) begin
			held_bytes[held_len] = b;
			held_len++;
			// a full line goes out at once
			if (held_len == LINE_BYTES) begin
				emit_line(held_len);
				held_len = 0;
			end
		end else begin
			// flush a partial line, then the terminating line
			if (held_len > 0)
				emit_line(held_len);
			push_char(CH_SP);
			push_char(CH_NL);
			held_len = 0;
		end
		// final character caused by this transaction carries the last flag
		if (pending_chars.size() > first)
			pending_chars[pending_chars.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// result checking, sampled at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		enc_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character %h last %b", $time, out_char,
					last_of_run);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t: out_char expected %h actual %h", $time, want.ch,
						out_char);
					errors++;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run expected %b actual %b", $time,
						want.last, last_of_run);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: changing stall patterns, plus a long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       run_left;
		int       held;
		int       holds_done;
		mode       = RX_ALWAYS;
		mode_left  = 0;
		run_left   = 0;
		holds_done = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				// long hold-off so the line banks and job queue fill up
				out_ready = 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(RX_ALWAYS, RX_BURSTY));
					mode_left = $urandom_range(40, 200);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: begin
						out_ready = 1'b1;
					end
					RX_HALF: begin
						out_ready = ($urandom_range(0, 1) == 1);
					end
					RX_SPARSE: begin
						out_ready = ($urandom_range(0, 3) == 0);
					end
					default: begin
						// alternating runs of ready and stall
						if (run_left == 0) begin
							out_ready = ~out_ready;
							run_left  = $urandom_range(1, 10);
						end
						run_left--;
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog
	// ---------------------------------------------------------------
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------

	// one input transaction; bursts of random length, with idle gaps between while gaps_on is set
	task automatic send_item(input logic rt, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			repeat (gap) begin
				@(negedge clk);
				in_valid  = 1'b0;
				req_type  = 1'($urandom_range(0, 1));
				data_byte = 8'($urandom_range(0, 255));
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid  = 1'b1;
		req_type  = rt;
		data_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		encode_item(rt, b);
	endtask

	// drop valid and wait until every owed character has come out
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_line(input int len);
		for (int i = 0; i < len; i++)
			send_item(REQ_DATA, 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// end of input with nothing collected: only space and newline
	task automatic test_empty_end();
		send_item(REQ_END, 8'h00);
		send_item(REQ_END, 8'hff);
		wait_drain();
	endtask

	// partial lines of one to four bytes, padding of a short last group
	task automatic test_short_lines();
		send_item(REQ_DATA, 8'h00);
		send_item(REQ_END, 8'h5a);
		send_item(REQ_DATA, 8'hff);
		send_item(REQ_DATA, 8'h80);
		send_item(REQ_END, 8'h00);
		send_item(REQ_DATA, 8'hfc);
		send_item(REQ_DATA, 8'h03);
		send_item(REQ_DATA, 8'h0f);
		send_item(REQ_END, 8'hff);
		send_item(REQ_DATA, 8'hff);
		send_item(REQ_DATA, 8'hff);
		send_item(REQ_DATA, 8'hff);
		send_item(REQ_DATA, 8'h01);
		send_item(REQ_END, 8'ha5);
		wait_drain();
	endtask

	// a line that fills, end right after it, and the longest flush
	task automatic test_full_lines();
		send_line(LINE_BYTES);
		send_item(REQ_END, 8'h00);
		send_line(LINE_BYTES - 1);
		send_item(REQ_END, 8'hff);
		wait_drain();
	endtask

	// receiver holds off while the sender keeps offering bytes
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_reqs++;
		send_line(2 * LINE_BYTES + 7);
		send_item(REQ_END, 8'($urandom_range(0, 255)));
		gaps_on = 1'b1;
		wait_drain();
	endtask

	// random lines of mostly short length, a few spanning several lines
	task automatic test_random_stream();
		int sent;
		int len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(LINE_BYTES + 1, 2 * LINE_BYTES + 10);
			else
				len = $urandom_range(0, LINE_BYTES + 2);
			gaps_on = ($urandom_range(0, 3) != 0);
			send_line(len);
			send_item(REQ_END, 8'($urandom_range(0, 255)));
			sent += len + 1;
			if ($urandom_range(0, 4) == 0)
				wait_drain();
		end
		gaps_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_DATA;
		data_byte  = 8'h00;
		held_len   = 0;
		errors     = 0;
		burst_left = 0;
		gaps_on    = 1'b1;
		hold_reqs  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_end();
		test_short_lines();
		test_full_lines();
		test_backpressure();
		test_random_stream();
		wait_drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
